// ----- sv/cme_pkg.sv -----
// ----------------------------------------------------------------------------
// cme_pkg: shared types and constants of the chord expander
// Event record, MIDI kind codes, register map and pitch-class helper.
// ----------------------------------------------------------------------------
package cme_pkg;

	localparam int NUM_REGS       = 6;
	localparam int REG_W          = 48;
	localparam int REG_IDX_W      = 3;
	localparam int OFFS_PER_CLASS = 3;

	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

	localparam logic [7:0] VEL_MAX = 8'd127;
	localparam logic [7:0] VEL_MIN = 8'd1;

	typedef logic [REG_W-1:0] chord_reg_t;

	typedef struct packed {
		logic [7:0]  status;
		logic [7:0]  first;
		logic [7:0]  second;
		logic [15:0] stamp;
	} evt_t;

	// note mod 12 by reciprocal multiply: q = (n * 171) >> 11 is exact for n < 256
	function automatic logic [3:0] pitch_class(input logic [7:0] n);
		logic [15:0] prod;
		logic [4:0]  q;
		logic [7:0]  r;
		prod = 16'(n) * 16'd171;
		q    = prod[15:11];
		r    = n - 8'(q) * 8'd12;
		return r[3:0];
	endfunction

endpackage

// ----- sv/cme_in_if.sv -----
// ----------------------------------------------------------------------------
// cme_in_if: MIDI event channel
// Valid/ready channel carrying one incoming MIDI event.
// ----------------------------------------------------------------------------
interface cme_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  status_byte;
	logic [7:0]  first_data;
	logic [7:0]  second_data;
	logic [15:0] event_time;

	modport source (output valid, status_byte, first_data, second_data, event_time,
		input ready);
	modport sink (input valid, status_byte, first_data, second_data, event_time,
		output ready);
endinterface

// ----- sv/cme_out_if.sv -----
// ----------------------------------------------------------------------------
// cme_out_if: chord note channel
// Valid/ready channel carrying one generated note or passthrough event.
// ----------------------------------------------------------------------------
interface cme_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_status;
	logic [7:0]  out_first;
	logic [7:0]  out_second;
	logic [15:0] out_time;
	logic        last_of_run;

	modport source (output valid, out_status, out_first, out_second, out_time,
		last_of_run, input ready);
	modport sink (input valid, out_status, out_first, out_second, out_time,
		last_of_run, output ready);
endinterface

// ----- sv/cme_regs.sv -----
// ----------------------------------------------------------------------------
// cme_regs: chord offset register file
// Six 48-bit registers, two pitch classes each; out-of-map writes dropped.
// ----------------------------------------------------------------------------
module cme_regs
	import cme_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  chord_reg_t           cfg_wdata,
	output chord_reg_t           regs_q [NUM_REGS]
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (cfg_index == REG_IDX_W'(i)) begin
					regs_q[i] <= cfg_wdata;
				end
			end
		end
	end

endmodule

// ----- sv/cme_expand.sv -----
// ----------------------------------------------------------------------------
// cme_expand: chord lane builder
// Turns one registered event into per-lane notes, a lane mask and a velocity
// (the unclamped second data byte for non-note events).
module cme_expand
	import cme_pkg::*;
#(
	parameter int CHORD_NOTES = 3
) (
	input  evt_t                   evt,
	input  chord_reg_t             regs_q [NUM_REGS],
	output logic [CHORD_NOTES-1:0] lane_mask,
	output logic [7:0]             lane_note [CHORD_NOTES],
	output logic [7:0]             second
);

	logic [3:0]       pclass;
	logic             is_note;
	chord_reg_t       sel_reg;
	logic [23:0]      class_offs;
	logic signed [7:0] offs [OFFS_PER_CLASS];
	logic signed [9:0] sum  [CHORD_NOTES];
	logic [7:0]       vel;

	assign pclass  = pitch_class(evt.first);
	assign is_note = (evt.status[7:4] == KIND_NOTE_ON) || (evt.status[7:4] == KIND_NOTE_OFF);
	assign sel_reg = regs_q[pclass[3:1]];

	always_comb begin
		case (pclass[0])
			1'b0:    class_offs = sel_reg[23:0];
			1'b1:    class_offs = sel_reg[47:24];
			default: class_offs = sel_reg[23:0];
		endcase
		for (int j = 0; j < OFFS_PER_CLASS; j++) begin
			offs[j] = signed'(class_offs[8*j +: 8]);
		end
	end

	// clamp velocity into 1..127
	always_comb begin
		if (evt.second > VEL_MAX) begin
			vel = VEL_MAX;
		end else if (evt.second < VEL_MIN) begin
			vel = VEL_MIN;
		end else begin
			vel = evt.second;
		end
	end

	always_comb begin
		for (int i = 0; i < CHORD_NOTES; i++) begin
			sum[i]       = signed'({2'b00, evt.first}) + 10'(offs[i]);
			lane_note[i] = sum[i][7:0];
			// keep notes in 0..127; drop repeats of the root offset
			lane_mask[i] = (sum[i][9:7] == 3'b000) && ((i == 0) || (offs[i] != offs[0]));
		end
		second = vel;
		if (!is_note) begin
			lane_mask    = CHORD_NOTES'(1);
			lane_note[0] = evt.first;
			second       = evt.second;
		end
	end

endmodule

// ----- sv/cme_emit.sv -----
// ----------------------------------------------------------------------------
// cme_emit: chord note emitter
// Holds one expanded event and drains its lanes, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module cme_emit
	import cme_pkg::*;
#(
	parameter int CHORD_NOTES = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  evt_t                   evt,
	input  logic [CHORD_NOTES-1:0] lane_mask,
	input  logic [7:0]             lane_note [CHORD_NOTES],
	input  logic [7:0]             second,
	output logic                   load_ok,
	cme_out_if.source              notes
);

	logic [CHORD_NOTES-1:0] mask_s2;
	logic [7:0]             note_s2 [CHORD_NOTES];
	evt_t                   evt_s2;
	logic [7:0]             second_s2;

	logic                   out_valid_q;
	logic                   out_free;
	logic                   pop;
	logic                   found;
	logic [7:0]             pick_note;
	logic [CHORD_NOTES-1:0] rest_mask;

	assign out_free = !out_valid_q || notes.ready;
	assign pop      = out_free && (mask_s2 != '0);
	assign load_ok  = (mask_s2 == '0) || (pop && (rest_mask == '0));

	// lowest pending lane goes out first
	always_comb begin
		found     = 1'b0;
		pick_note = note_s2[0];
		rest_mask = mask_s2;
		for (int i = 0; i < CHORD_NOTES; i++) begin
			if (mask_s2[i] && !found) begin
				found        = 1'b1;
				pick_note    = note_s2[i];
				rest_mask[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_s2 <= lane_mask;
			end else if (pop) begin
				mask_s2 <= rest_mask;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (notes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			note_s2   <= lane_note;
			evt_s2    <= evt;
			second_s2 <= second;
		end
		if (pop) begin
			notes.out_status  <= evt_s2.status;
			notes.out_first   <= pick_note;
			notes.out_second  <= second_s2;
			notes.out_time    <= evt_s2.stamp;
			notes.last_of_run <= (rest_mask == '0);
		end
	end

	assign notes.valid = out_valid_q;

endmodule

// ----- sv/midi_note_chord_expander.sv -----
// ----------------------------------------------------------------------------
// midi_note_chord_expander: MIDI chord generator
// Expands note-on/off events into up to CHORD_NOTES transposed notes.
// ----------------------------------------------------------------------------
// Each event passes an input register, then combinational expansion (pitch
// class, offset lookup, range and duplicate checks, velocity clamp) into the
// emitter stage, which drives one result per cycle from its output register
// while notes.ready does not stall it. An event holds the emitter until its
// results (0 to CHORD_NOTES) are sent, and the next event is taken in the
// cycle its last result is sent, so throughput is set by the single output
// port: one result per clock unless the output stalls. The first result is
// registered in the input register, the emitter's lane register and the
// output register in turn. Non-note events pass through as a single result.
// Offset registers are written through the cfg port at any index below six;
// other indexes are dropped. Write them only while idle.
// ----------------------------------------------------------------------------
module midi_note_chord_expander
	import cme_pkg::*;
#(
	parameter int CHORD_NOTES = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	cme_in_if.sink               events,
	cme_out_if.source            notes
);

	chord_reg_t             regs_q [NUM_REGS];
	logic                   valid_s1;
	evt_t                   evt_s1;
	logic                   load_ok;
	logic                   load;
	logic [CHORD_NOTES-1:0] lane_mask;
	logic [7:0]             lane_note [CHORD_NOTES];
	logic [7:0]             second;

	cme_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.regs_q    (regs_q)
	);

	// Input register: take a new event when none is held or the held one moves on.
	assign load         = valid_s1 && load_ok;
	assign events.ready = !valid_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.ready && events.valid) begin
			evt_s1 <= '{status: events.status_byte, first: events.first_data,
				second: events.second_data, stamp: events.event_time};
		end
	end

	cme_expand #(.CHORD_NOTES(CHORD_NOTES)) u_expand (
		.evt       (evt_s1),
		.regs_q    (regs_q),
		.lane_mask (lane_mask),
		.lane_note (lane_note),
		.second    (second)
	);

	// Emitter: hold the expanded event, drain its lanes into the output register.
	cme_emit #(.CHORD_NOTES(CHORD_NOTES)) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.evt       (evt_s1),
		.lane_mask (lane_mask),
		.lane_note (lane_note),
		.second    (second),
		.load_ok   (load_ok),
		.notes     (notes)
	);

endmodule
